// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the shadow volume index generator RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SVIG_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("svig assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SVIG_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("svig assertion failed");

`endif

// ----- rtl/svig_pkg.sv -----
// Shared types and constants for the shadow volume index generator.
// No dependencies; imported by the controller, datapath and top level.
package svig_pkg;

  localparam int MAX_FACES_DEF = 4096;

  localparam logic [15:0] NONE_FACE = 16'hFFFF;

  // configuration register indexes
  localparam logic [2:0] REG_LIGHT_IS_POINT = 3'd0;
  localparam logic [2:0] REG_LIGHT_X        = 3'd1;
  localparam logic [2:0] REG_LIGHT_Y        = 3'd2;
  localparam logic [2:0] REG_LIGHT_Z        = 3'd3;
  localparam logic [2:0] REG_FIRST_FACE     = 3'd4;

  // last emit step of a cap triangle and of an extruded quad
  localparam logic [2:0] CAP_LAST  = 3'd2;
  localparam logic [2:0] QUAD_LAST = 3'd5;

  // dot product term selects
  localparam logic [1:0] TERM_X = 2'd0;
  localparam logic [1:0] TERM_Y = 2'd1;
  localparam logic [1:0] TERM_Z = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLASSIFY  = 2'd0,
    KIND_DARK_CAP  = 2'd1,
    KIND_LIGHT_CAP = 2'd2,
    KIND_EDGE      = 2'd3
  } kind_t;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       prod_en;
    logic [1:0] term_sel;
    logic       acc_load;
    logic       acc_add;
    logic       store;
    logic       emit;
    logic [2:0] emit_idx;
    logic       emit_quad;
    logic       emit_swap;
    logic       emit_add;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  none0;
    logic  none1;
    logic  ok0;
    logic  ok1;
    logic  lit0;
    logic  lit1;
    logic  clear_last;
  } sts_t;

endpackage

// ----- rtl/svig_dp.sv -----
// Datapath: config registers, item capture, lit table memory, dot product MAC, result regs.
// Depends on svig_pkg.
module svig_dp import svig_pkg::*; #(
  parameter int MAX_FACES = MAX_FACES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         kind,
  input  logic [15:0]        face_index,
  input  logic [15:0]        second_face_index,
  input  logic [15:0]        vertex_a,
  input  logic [15:0]        vertex_b,
  input  logic [15:0]        vertex_c,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output logic               result_strobe,
  output logic [15:0]        vertex_out,
  output logic               face_lit,
  output logic               last
);

  localparam int SLOT_W = $clog2(MAX_FACES);
  localparam int PROD_W = 33;
  localparam int ACC_W  = 35;

  // configuration
  logic               light_is_point;
  logic signed [15:0] light_x;
  logic signed [15:0] light_y;
  logic signed [15:0] light_z;
  logic [15:0]        first_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_is_point <= 1'b0;
      light_x        <= '0;
      light_y        <= '0;
      light_z        <= '0;
      first_face     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LIGHT_IS_POINT: light_is_point <= wr_data[0];
        REG_LIGHT_X:        light_x        <= wr_data;
        REG_LIGHT_Y:        light_y        <= wr_data;
        REG_LIGHT_Z:        light_z        <= wr_data;
        REG_FIRST_FACE:     first_face     <= wr_data;
        default: ;
      endcase
    end
  end

  // slot of each face and range test
  logic [15:0] slot0_full;
  logic [15:0] slot1_full;
  logic        in_range0;
  logic        in_range1;

  assign slot0_full = face_index - first_face;
  assign slot1_full = second_face_index - first_face;
  assign in_range0  = {1'b0, slot0_full} < 17'(MAX_FACES);
  assign in_range1  = {1'b0, slot1_full} < 17'(MAX_FACES);

  // captured item
  kind_t              kind_q;
  logic [15:0]        va;
  logic [15:0]        vb;
  logic [15:0]        vc;
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] dz;
  logic [SLOT_W-1:0]  slot0;
  logic [SLOT_W-1:0]  slot1;
  logic               none0;
  logic               none1;
  logic               ok0;
  logic               ok1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind_t'(kind);
      va     <= vertex_a;
      vb     <= vertex_b;
      vc     <= vertex_c;
      nx     <= normal_x;
      ny     <= normal_y;
      nz     <= normal_z;
      dx     <= light_is_point ? 17'(point_x) - 17'(light_x) : 17'(light_x);
      dy     <= light_is_point ? 17'(point_y) - 17'(light_y) : 17'(light_y);
      dz     <= light_is_point ? 17'(point_z) - 17'(light_z) : 17'(light_z);
      slot0  <= slot0_full[SLOT_W-1:0];
      slot1  <= slot1_full[SLOT_W-1:0];
      none0  <= face_index == NONE_FACE;
      none1  <= second_face_index == NONE_FACE;
      ok0    <= (face_index != NONE_FACE) && in_range0;
      ok1    <= (second_face_index != NONE_FACE) && in_range1;
    end
  end

  // dot product: one multiply per cycle, product registered, then accumulated
  logic signed [15:0]       n_sel;
  logic signed [16:0]       d_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_pos;

  always_comb begin
    case (cmd.term_sel)
      TERM_X: begin
        n_sel = nx;
        d_sel = dx;
      end
      TERM_Y: begin
        n_sel = ny;
        d_sel = dy;
      end
      default: begin
        n_sel = nz;
        d_sel = dz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= PROD_W'(n_sel) * PROD_W'(d_sel);
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign acc_pos = !acc[ACC_W-1] && (acc != '0);

  // lit table, cleared by a sweep after reset
  logic              mem [MAX_FACES];
  logic [SLOT_W-1:0] clr_cnt;
  logic              rd0;
  logic              rd1;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic              mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + SLOT_W'(1);
    end
  end

  assign mem_we    = cmd.clear || cmd.store;
  assign mem_waddr = cmd.clear ? clr_cnt : slot0;
  assign mem_wdata = cmd.clear ? 1'b0 : acc_pos;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd0 <= mem[slot0];
    rd1 <= mem[slot1];
  end

  assign sts.kind       = kind_q;
  assign sts.none0      = none0;
  assign sts.none1      = none1;
  assign sts.ok0        = ok0;
  assign sts.ok1        = ok1;
  assign sts.lit0       = rd0;
  assign sts.lit1       = rd1;
  assign sts.clear_last = clr_cnt == SLOT_W'(MAX_FACES - 1);

  // emitted vertex select
  logic [15:0] p;
  logic [15:0] q;
  logic [15:0] inc;
  logic [15:0] emit_vtx;

  assign p   = cmd.emit_swap ? vb : va;
  assign q   = cmd.emit_swap ? va : vb;
  assign inc = {15'd0, cmd.emit_add};

  always_comb begin
    if (cmd.emit_quad) begin
      case (cmd.emit_idx)
        3'd0:    emit_vtx = p;
        3'd1:    emit_vtx = q;
        3'd2:    emit_vtx = p + 16'd1;
        3'd3:    emit_vtx = q;
        3'd4:    emit_vtx = q + 16'd1;
        default: emit_vtx = p + 16'd1;
      endcase
    end else begin
      case (cmd.emit_idx)
        3'd0:    emit_vtx = va + inc;
        3'd1:    emit_vtx = vc + inc;
        default: emit_vtx = vb + inc;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit || cmd.store;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      vertex_out <= '0;
      face_lit   <= acc_pos;
      last       <= 1'b1;
    end else if (cmd.emit) begin
      vertex_out <= emit_vtx;
      face_lit   <= 1'b0;
      last       <= cmd.emit_last;
    end
  end

endmodule

// ----- rtl/svig_ctrl.sv -----
// Controller: sequences table clear, classify MAC steps and index emission.
// Depends on svig_pkg.
module svig_ctrl import svig_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_STORE,
    S_EMIT
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] idx;
  logic       quad;
  logic       swap;
  logic       add;
  logic       gen;
  logic       gen_quad;
  logic       gen_swap;
  logic       gen_add;
  logic       emit_last;

  // what a cap or edge item produces, from the lit bits read in LOOKUP
  always_comb begin
    gen      = 1'b0;
    gen_quad = 1'b0;
    gen_swap = 1'b0;
    gen_add  = 1'b0;
    case (sts.kind)
      KIND_DARK_CAP: begin
        gen = sts.ok0 && sts.lit0;
      end
      KIND_LIGHT_CAP: begin
        gen     = sts.ok0 && !sts.lit0;
        gen_add = 1'b1;
      end
      KIND_EDGE: begin
        gen_quad = 1'b1;
        if (sts.none0 && sts.none1) begin
          gen = 1'b0;
        end else if (!sts.none0 && !sts.none1) begin
          gen      = sts.ok0 && sts.ok1 && (sts.lit0 != sts.lit1);
          gen_swap = !sts.lit0;
        end else if (!sts.none0) begin
          gen      = sts.ok0;
          gen_swap = !sts.lit0;
        end else begin
          gen      = sts.ok1;
          gen_swap = !sts.lit1;
        end
      end
      default: gen = 1'b0;
    endcase
  end

  assign emit_last = quad ? (idx == QUAD_LAST) : (idx == CAP_LAST);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_LOOKUP;
      S_LOOKUP: begin
        if (sts.kind == KIND_CLASSIFY) begin
          state_next = sts.ok0 ? S_MUL0 : S_IDLE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = gen ? S_EMIT : S_IDLE;
      S_MUL0:   state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_SUM;
      S_SUM:    state_next = S_STORE;
      S_STORE:  state_next = S_IDLE;
      S_EMIT:   if (emit_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      quad  <= 1'b0;
      swap  <= 1'b0;
      add   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECIDE) begin
        idx  <= '0;
        quad <= gen_quad;
        swap <= gen_swap;
        add  <= gen_add;
      end else if (state == S_EMIT) begin
        idx <= idx + 3'd1;
      end
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == S_IDLE) && start;
    cmd.clear     = state == S_CLEAR;
    cmd.prod_en   = (state == S_MUL0) || (state == S_MUL1) || (state == S_MUL2);
    cmd.term_sel  = (state == S_MUL0) ? TERM_X : ((state == S_MUL1) ? TERM_Y : TERM_Z);
    cmd.acc_load  = state == S_MUL1;
    cmd.acc_add   = (state == S_MUL2) || (state == S_SUM);
    cmd.store     = state == S_STORE;
    cmd.emit      = state == S_EMIT;
    cmd.emit_idx  = idx;
    cmd.emit_quad = quad;
    cmd.emit_swap = swap;
    cmd.emit_add  = add;
    cmd.emit_last = emit_last;
  end

endmodule

// ----- rtl/shadow_volume_index_generator.sv -----
// Top level of the shadow volume index generator: controller plus datapath.
// Depends on svig_pkg, svig_ctrl, svig_dp and assert_macros.svh.
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  item in   start & !busy          kind, face/second_face_index, vertex_a/b/c,
//                                   normal_x/y/z, point_x/y/z
//  config    wr_en                  wr_index (0..4), wr_data
//  result    result_strobe (1 cyc)  vertex_out, face_lit, last
//
// One transaction at a time. A classify item passes LOOKUP, MUL0, MUL1, MUL2,
// SUM and STORE before its result is registered (three 16x17 multiplies through
// one shared multiplier, then the table write); a cap item emits 3 results and
// an edge item 6, one per cycle, after LOOKUP and DECIDE. Items that yield
// nothing free the block from LOOKUP or DECIDE.
// After rst the lit table is swept to unlit, one entry per cycle, with busy
// high; config writes are taken during the sweep.
// Results cannot be stalled; each strobe lasts exactly one cycle.
`include "assert_macros.svh"

module shadow_volume_index_generator import svig_pkg::*; #(
  parameter int MAX_FACES = MAX_FACES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [15:0]        face_index,
  input  logic [15:0]        second_face_index,
  input  logic [15:0]        vertex_a,
  input  logic [15:0]        vertex_b,
  input  logic [15:0]        vertex_c,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output logic               result_strobe,
  output logic [15:0]        vertex_out,
  output logic               face_lit,
  output logic               last
);

  // controller drives commands, datapath reports item flags and table bits
  cmd_t cmd;
  sts_t sts;

  svig_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  svig_dp #(
    .MAX_FACES (MAX_FACES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .kind              (kind),
    .face_index        (face_index),
    .second_face_index (second_face_index),
    .vertex_a          (vertex_a),
    .vertex_b          (vertex_b),
    .vertex_c          (vertex_c),
    .normal_x          (normal_x),
    .normal_y          (normal_y),
    .normal_z          (normal_z),
    .point_x           (point_x),
    .point_y           (point_y),
    .point_z           (point_z),
    .wr_en             (wr_en),
    .wr_index          (wr_index),
    .wr_data           (wr_data),
    .result_strobe     (result_strobe),
    .vertex_out        (vertex_out),
    .face_lit          (face_lit),
    .last              (last)
  );

  // the cycle after an accept never carries a result of the new or an old item
  `SVIG_ASSERT_NXT(a_quiet_after_accept, clk, rst, start && !busy, !result_strobe)
  // the last result of a transaction is never directly followed by another
  `SVIG_ASSERT_NXT(a_gap_after_last, clk, rst, result_strobe && last, !result_strobe)
  // table writes from classify only hit faces inside the table
  `SVIG_ASSERT_IMP(a_store_in_range, clk, rst, cmd.store, sts.ok0 && !cmd.clear)
  // a lit flag only rides on a single-result classify transaction
  `SVIG_ASSERT_IMP(a_lit_is_last, clk, rst, result_strobe && face_lit, last)

endmodule
